@@ hdl/pulse_width_packet_receiver_crc8_macros.svh @@
// Assertion macros used by the pulse-width receiver core (pwpr_core).
`ifndef PULSE_WIDTH_PACKET_RECEIVER_CRC8_MACROS_SVH
`define PULSE_WIDTH_PACKET_RECEIVER_CRC8_MACROS_SVH

// same-cycle implication, checked outside reset
`define PWPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PWPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pwpr_pkg.sv @@
// Package: types, constants and the CRC-8 step of the pulse-width receiver.
`default_nettype none

package pwpr_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [15:0] RESET_LOW_THRESHOLD = 16'd8;
  localparam logic [15:0] RESET_PHASE_TIMEOUT = 16'd100;
  localparam logic [7:0]  RESET_MIN_PREAMBLE  = 8'd20;
  localparam logic [3:0]  RESET_SYNC_BITS     = 4'd6;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PREAMBLE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BITS     = 2'd3;

  typedef enum logic [1:0] {
    STG_PRE  = 2'd0,
    STG_SYNC = 2'd1,
    STG_DATA = 2'd2
  } stage_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_CRC  = 2'd1,
    STATUS_LEN  = 2'd2,
    STATUS_SYNC = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] low_threshold;
    logic [15:0] phase_timeout;
    logic [7:0]  min_preamble;
    logic [3:0]  sync_bits;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    status_t    status;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pulse_width_packet_receiver_crc8.sv @@
// Top level of the pulse-width packet receiver with CRC-8 check.
//
// Input channel: one line_sample beat per tick, taken when in_valid is high and
// in_stall is low. Output channel: a result beat (byte_valid/data_byte for the
// length and payload bytes, frame_done/status at the end of a frame attempt) is
// taken when out_valid is high and out_stall is low. Samples that decode to no
// result leave nothing on the output.
// An accepted sample lands in the input register; when it advances, the decoder
// updates its state and loads any result into the output register, which drives
// out_valid and the result ports. Throughput: one sample per cycle while
// in_stall is low; the bit timer, frame state machine and CRC-8 byte update all
// settle between the input and output registers.
// Reset (rst, synchronous): valid flags, configuration and decoder state return
// to defaults, the decoder goes to the preamble hunt, and both channels empty.
// Stall: while a result waits on a stalled output, samples that give no result
// keep flowing; a sample that gives one holds in the input register, and
// in_stall rises only when that register is full and cannot move.
// Configuration writes are taken on any edge with cfg_write high and rst low.
`default_nettype none

module pulse_width_packet_receiver_crc8
  import pwpr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   line_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        byte_valid,
  output logic [7:0]                  data_byte,
  output logic                        frame_done,
  output logic [1:0]                  status
);

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    in_reg_valid;
  logic    in_reg_sample;
  logic    out_free;
  logic    advance;

  pwpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwpr_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .sample (in_reg_sample),
    .res    (core_res)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && (!core_res.valid || out_free);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else begin
      in_reg_valid <= in_stall || in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg_sample <= line_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && core_res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.valid) begin
      out_res <= core_res;
    end
  end

  assign byte_valid = out_res.byte_valid;
  assign data_byte  = out_res.data_byte;
  assign frame_done = out_res.frame_done;
  assign status     = out_res.status;

endmodule

`default_nettype wire

@@ hdl/pwpr_cfg.sv @@
// Configuration register file of the pulse-width receiver.
`default_nettype none

module pwpr_cfg
  import pwpr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold <= RESET_LOW_THRESHOLD;
      cfg.phase_timeout <= RESET_PHASE_TIMEOUT;
      cfg.min_preamble  <= RESET_MIN_PREAMBLE;
      cfg.sync_bits     <= RESET_SYNC_BITS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD: cfg.low_threshold <= cfg_data;
        REG_PHASE_TIMEOUT: cfg.phase_timeout <= cfg_data;
        REG_MIN_PREAMBLE:  cfg.min_preamble  <= cfg_data[7:0];
        REG_SYNC_BITS:     cfg.sync_bits     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/pwpr_core.sv @@
// Bit decoder and frame state machine: one line sample per step.
`default_nettype none
`include "pulse_width_packet_receiver_crc8_macros.svh"

module pwpr_core
  import pwpr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic step,
  input  wire logic sample,
  output result_t   res
);

  localparam logic [7:0] PB8 = 8'(PAYLOAD_BYTES);
  localparam logic [7:0] BYTE_INDEX_MAX = 8'(PAYLOAD_BYTES + 1);

  stage_t      stage, stage_next;
  logic        low_phase, low_phase_next;
  logic [15:0] high_count, high_count_next;
  logic [15:0] low_count, low_count_next;
  logic        last_bit, last_bit_next;
  logic        first_bit_seen, first_bit_seen_next;
  logic [7:0]  preamble_count, preamble_count_next;
  logic [3:0]  sync_count, sync_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  crc_reg, crc_reg_next;
  logic [7:0]  length_byte, length_byte_next;

  logic        bit_done, bit_val, rearm;
  logic [3:0]  sync_inc;
  logic [7:0]  pre_inc;
  logic [7:0]  shift_in;
  logic [2:0]  bit_inc;

  assign sync_inc = sync_count + 4'd1;
  assign pre_inc  = (preamble_count < 8'd255) ? preamble_count + 8'd1 : preamble_count;
  assign shift_in = {shift_byte[6:0], bit_val};
  assign bit_inc  = bit_index + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= STG_PRE;
      low_phase      <= 1'b0;
      high_count     <= '0;
      low_count      <= '0;
      last_bit       <= 1'b0;
      first_bit_seen <= 1'b0;
      preamble_count <= '0;
      sync_count     <= '0;
      shift_byte     <= '0;
      bit_index      <= '0;
      byte_index     <= '0;
      crc_reg        <= CRC_INIT;
      length_byte    <= '0;
    end else if (step) begin
      stage          <= stage_next;
      low_phase      <= low_phase_next;
      high_count     <= high_count_next;
      low_count      <= low_count_next;
      last_bit       <= last_bit_next;
      first_bit_seen <= first_bit_seen_next;
      preamble_count <= preamble_count_next;
      sync_count     <= sync_count_next;
      shift_byte     <= shift_byte_next;
      bit_index      <= bit_index_next;
      byte_index     <= byte_index_next;
      crc_reg        <= crc_reg_next;
      length_byte    <= length_byte_next;
    end
  end

  always_comb begin
    stage_next          = stage;
    low_phase_next      = low_phase;
    high_count_next     = high_count;
    low_count_next      = low_count;
    last_bit_next       = last_bit;
    first_bit_seen_next = first_bit_seen;
    preamble_count_next = preamble_count;
    sync_count_next     = sync_count;
    shift_byte_next     = shift_byte;
    bit_index_next      = bit_index;
    byte_index_next     = byte_index;
    crc_reg_next        = crc_reg;
    length_byte_next    = length_byte;
    res.valid      = 1'b0;
    res.byte_valid = 1'b0;
    res.data_byte  = '0;
    res.frame_done = 1'b0;
    res.status     = STATUS_OK;
    bit_done = 1'b0;
    bit_val  = 1'b0;
    rearm    = 1'b0;

    // pulse timing
    if (!low_phase) begin
      if (sample) begin
        if (high_count < cfg.phase_timeout) begin
          high_count_next = high_count + 16'd1;
        end else begin
          bit_done = 1'b1;
        end
      end else if (cfg.phase_timeout == '0) begin
        bit_done = 1'b1;
      end else begin
        low_count_next = 16'd1;
        low_phase_next = 1'b1;
      end
    end else if (!sample && low_count < cfg.phase_timeout) begin
      low_count_next = low_count + 16'd1;
    end else begin
      bit_done = 1'b1;
      bit_val  = low_count > cfg.low_threshold;
    end

    if (bit_done) begin
      high_count_next = '0;
      low_count_next  = '0;
      low_phase_next  = 1'b0;
      unique case (stage)
        STG_SYNC: begin
          sync_count_next = sync_inc;
          if (sync_inc >= cfg.sync_bits) begin
            if (bit_val) begin
              stage_next = STG_DATA;
            end else begin
              rearm          = 1'b1;
              res.valid      = 1'b1;
              res.frame_done = 1'b1;
              res.status     = STATUS_SYNC;
            end
          end
        end
        STG_DATA: begin
          shift_byte_next = shift_in;
          bit_index_next  = bit_inc;
          if (bit_inc == '0) begin
            shift_byte_next = '0;
            if (byte_index <= PB8) begin
              if (byte_index == '0) begin
                length_byte_next = shift_in;
              end
              crc_reg_next    = crc8_byte(crc_reg, shift_in);
              byte_index_next = byte_index + 8'd1;
              res.valid      = 1'b1;
              res.byte_valid = 1'b1;
              res.data_byte  = shift_in;
            end else begin
              rearm          = 1'b1;
              res.valid      = 1'b1;
              res.frame_done = 1'b1;
              if (shift_in != crc_reg) begin
                res.status = STATUS_CRC;
              end else if (length_byte > PB8) begin
                res.status = STATUS_LEN;
              end else begin
                res.status = STATUS_OK;
              end
            end
          end
        end
        default: begin
          if (!first_bit_seen) begin
            first_bit_seen_next = 1'b1;
            last_bit_next       = bit_val;
            preamble_count_next = 8'd1;
          end else begin
            preamble_count_next = pre_inc;
            if (bit_val != last_bit) begin
              last_bit_next = bit_val;
            end else if (pre_inc >= cfg.min_preamble && bit_val) begin
              sync_count_next = '0;
              stage_next      = (cfg.sync_bits == '0) ? STG_DATA : STG_SYNC;
            end else begin
              rearm          = 1'b1;
              res.valid      = 1'b1;
              res.frame_done = 1'b1;
              res.status     = STATUS_SYNC;
            end
          end
        end
      endcase
    end

    if (rearm) begin
      stage_next          = STG_PRE;
      low_phase_next      = 1'b0;
      high_count_next     = '0;
      low_count_next      = '0;
      last_bit_next       = 1'b0;
      first_bit_seen_next = 1'b0;
      preamble_count_next = '0;
      sync_count_next     = '0;
      shift_byte_next     = '0;
      bit_index_next      = '0;
      byte_index_next     = '0;
      crc_reg_next        = CRC_INIT;
      length_byte_next    = '0;
    end
  end

  `PWPR_ASSERT_NOW(a_one_kind, res.valid, res.byte_valid != res.frame_done, "result is both byte and status")
  `PWPR_ASSERT_NOW(a_bit_index_data, stage != STG_DATA, bit_index == '0, "bit index moved outside data")
  `PWPR_ASSERT_NOW(a_byte_index_max, 1'b1, byte_index <= BYTE_INDEX_MAX, "byte index past CRC byte")
  `PWPR_ASSERT_NEXT(a_rearm, step && res.frame_done, stage == STG_PRE && crc_reg == CRC_INIT, "no rearm after frame end")

endmodule

`default_nettype wire
